// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset
`define SGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset
`define SGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sgb_pkg.sv -----
// Package: constants, codes and control types of the glyph blitter
package sgb_pkg;

  // Font table and panel geometry
  localparam int GLYPH_SLOTS  = 64;
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int FONT_COLUMNS = 3;
  localparam int FONT_ROWS    = 5;
  localparam int FONT_DOTS    = FONT_COLUMNS * FONT_ROWS;

  localparam int SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int STEP_W = $clog2(FONT_DOTS);
  localparam int ROW_W  = $clog2(FONT_ROWS);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int SLOTF_W = 6;
  localparam int CODE_W  = 8;
  localparam int DOTS_W  = 15;
  localparam int POS_W   = 16;
  localparam int SCALE_W = 4;
  localparam int PIX_W   = 8;
  localparam int XO_W    = 7;
  localparam int YO_W    = 6;

  // Working width of square corners: pen plus a few dot sizes, and the panel size
  localparam int COORD_W = 18;
  localparam int PEN_MAX = 32767;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic scan;
    logic emit;
    logic flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_draw;
    logic hit;
    logic scan_end;
    logic emit_end;
    logic flush_done;
    logic pend_busy;
  } sts_t;

endpackage

// ----- rtl/sgb_if.sv -----
// Interfaces: input item channel and result square channel

interface sgb_in_if;
  import sgb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [SLOTF_W-1:0]        slot;
  logic [CODE_W-1:0]         char_code;
  logic [DOTS_W-1:0]         glyph_bits;
  logic signed [POS_W-1:0]   start_x;
  logic signed [POS_W-1:0]   start_y;
  logic [SCALE_W-1:0]        scale;
  logic [PIX_W-1:0]          pixel_value;

  modport source (output valid, kind, slot, char_code, glyph_bits, start_x, start_y,
                  scale, pixel_value, input ready);
  modport sink (input valid, kind, slot, char_code, glyph_bits, start_x, start_y,
                scale, pixel_value, output ready);
endinterface

interface sgb_out_if;
  import sgb_pkg::*;
  logic              valid;
  logic              ready;
  logic [XO_W-1:0]   x_first;
  logic [XO_W-1:0]   x_last;
  logic [YO_W-1:0]   y_first;
  logic [YO_W-1:0]   y_last;
  logic [PIX_W-1:0]  fill_value;
  logic              last;

  modport source (output valid, x_first, x_last, y_first, y_last, fill_value, last,
                  input ready);
  modport sink (input valid, x_first, x_last, y_first, y_last, fill_value, last,
                output ready);
endinterface

// ----- rtl/sgb_ctrl.sv -----
// Controller: sequences lookup scan, dot emission and final flush of a draw
module sgb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  sgb_pkg::sts_t sts,
  output sgb_pkg::cmd_t cmd
);
  import sgb_pkg::*;
  `include "assert_macros.svh"

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid && sts.in_draw) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_next = ST_EMIT;
        end else if (sts.scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.flush_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SGB_ASSERT_NOW(a_idle_no_pending, state == ST_IDLE, !sts.pend_busy, "square left pending in idle")
  `SGB_ASSERT_NOW(a_scan_quiet, state == ST_SCAN, !sts.pend_busy, "square pending during lookup")
  `SGB_ASSERT_NEXT(a_flush_done, state == ST_FLUSH && sts.flush_done, !sts.pend_busy, "flush left a square")

endmodule

// ----- rtl/sgb_datapath.sv -----
// Datapath: font memory, pen state, slot scan, dot clipping and result staging
module sgb_datapath (
  input  logic          clk,
  input  logic          rst,
  input  sgb_pkg::cmd_t cmd,
  output sgb_pkg::sts_t sts,
  sgb_in_if.sink        item,
  sgb_out_if.source     result
);
  import sgb_pkg::*;
  `include "assert_macros.svh"

  localparam logic signed [COORD_W-1:0] C_ZERO  = '0;
  localparam logic signed [COORD_W-1:0] C_PW    = COORD_W'(PANEL_WIDTH);
  localparam logic signed [COORD_W-1:0] C_PH    = COORD_W'(PANEL_HEIGHT);
  localparam logic signed [COORD_W-1:0] C_PWM1  = COORD_W'(PANEL_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] C_PHM1  = COORD_W'(PANEL_HEIGHT - 1);
  localparam logic signed [COORD_W-1:0] C_PMAX  = COORD_W'(PEN_MAX);
  localparam logic [SLOT_W:0]           SLOTS_N = (SLOT_W+1)'(GLYPH_SLOTS);
  localparam logic [SLOT_W-1:0]         SLOT_LAST = SLOT_W'(GLYPH_SLOTS - 1);
  localparam logic [STEP_W-1:0]         STEP_LAST = STEP_W'(FONT_DOTS - 1);
  localparam logic [ROW_W-1:0]          ROW_LAST  = ROW_W'(FONT_ROWS - 1);
  localparam logic [8:0]                SLOTS_CMP = 9'(GLYPH_SLOTS);

  // Font memory: code and dots per slot
  logic [CODE_W+DOTS_W-1:0] font_mem [GLYPH_SLOTS];
  logic [GLYPH_SLOTS-1:0]   slot_valid;

  // Pen state
  logic signed [POS_W-1:0]  pen_col;
  logic signed [POS_W-1:0]  pen_row;
  logic [SCALE_W-1:0]       dot_size;
  logic [PIX_W-1:0]         ink;

  // Scan
  logic [CODE_W-1:0]        key;
  logic [SLOT_W:0]          issue_idx;
  logic [SLOT_W-1:0]        rd_idx;
  logic                     rd_live;
  logic [CODE_W+DOTS_W-1:0] rd_word;

  // Emit
  logic [DOTS_W-1:0]        dots;
  logic [STEP_W-1:0]        step;
  logic [ROW_W-1:0]         row_cnt;
  logic signed [COORD_W-1:0] col_base;
  logic signed [COORD_W-1:0] row_base;
  logic signed [COORD_W-1:0] row_start;

  // Pending square and output register
  logic              pend_valid;
  logic [XO_W-1:0]   pend_xf, pend_xl;
  logic [YO_W-1:0]   pend_yf, pend_yl;
  logic              out_valid;
  logic [XO_W-1:0]   out_xf, out_xl;
  logic [YO_W-1:0]   out_yf, out_yl;
  logic [PIX_W-1:0]  out_fill;
  logic              out_last;

  logic                      accept;
  logic                      is_load, is_start, is_draw;
  logic                      match;
  logic                      out_free;
  logic signed [COORD_W-1:0] s_ext, s_m1;
  logic signed [COORD_W-1:0] x_hi, y_hi, pen_sum;
  logic                      vis;
  logic [XO_W-1:0]           c_xf, c_xl;
  logic [YO_W-1:0]           c_yf, c_yl;
  logic                      adv;
  logic                      push_pend;

  assign item.ready = cmd.in_ready;
  assign accept     = item.valid && cmd.in_ready;
  assign is_load    = item.kind == KIND_LOAD;
  assign is_start   = item.kind == KIND_START;
  assign is_draw    = item.kind == KIND_DRAW;

  // Compare the registered read against the key
  assign match = rd_live && slot_valid[rd_idx] && (rd_word[CODE_W+DOTS_W-1:DOTS_W] == key);

  // Clip the current dot square
  assign s_ext = $signed(COORD_W'(dot_size));
  assign s_m1  = $signed(COORD_W'(dot_size - SCALE_W'(1)));
  assign x_hi  = col_base + s_m1;
  assign y_hi  = row_base + s_m1;
  assign vis   = dots[0] && (x_hi >= C_ZERO) && (col_base < C_PW)
                 && (y_hi >= C_ZERO) && (row_base < C_PH);
  assign c_xf  = (col_base < C_ZERO) ? '0 : col_base[XO_W-1:0];
  assign c_xl  = (x_hi >= C_PW) ? C_PWM1[XO_W-1:0] : x_hi[XO_W-1:0];
  assign c_yf  = (row_base < C_ZERO) ? '0 : row_base[YO_W-1:0];
  assign c_yl  = (y_hi >= C_PH) ? C_PHM1[YO_W-1:0] : y_hi[YO_W-1:0];

  assign out_free  = !out_valid || result.ready;
  assign adv       = cmd.emit && !(vis && pend_valid && !out_free);
  assign push_pend = adv && vis && pend_valid;

  // Pen advance with saturation
  assign pen_sum = $signed({{(COORD_W-POS_W){pen_col[POS_W-1]}}, pen_col})
                   + (s_ext <<< 2);

  // Font memory write and scan read
  always_ff @(posedge clk) begin
    if (accept && is_load && (9'(item.slot) < SLOTS_CMP)) begin
      font_mem[SLOT_W'(item.slot)] <= {item.char_code, item.glyph_bits};
    end
    if (cmd.scan && (issue_idx < SLOTS_N)) begin
      rd_word <= font_mem[issue_idx[SLOT_W-1:0]];
      rd_idx  <= issue_idx[SLOT_W-1:0];
    end
  end

  // Control state: valid bits, pen, scan, pending and output flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      pen_col    <= '0;
      pen_row    <= '0;
      dot_size   <= SCALE_W'(1);
      ink        <= '0;
      rd_live    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept && is_load && (9'(item.slot) < SLOTS_CMP)) begin
        slot_valid[SLOT_W'(item.slot)] <= 1'b1;
      end
      if (accept && is_start) begin
        pen_col  <= item.start_x;
        pen_row  <= item.start_y;
        dot_size <= (item.scale == '0) ? SCALE_W'(1) : item.scale;
        ink      <= item.pixel_value;
      end
      if (accept && is_draw) begin
        pen_col <= (pen_sum > C_PMAX) ? C_PMAX[POS_W-1:0] : pen_sum[POS_W-1:0];
      end
      // Track an outstanding read
      if (cmd.scan) begin
        rd_live <= issue_idx < SLOTS_N;
      end else begin
        rd_live <= 1'b0;
      end
      // Pending square
      if (adv && vis) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush && out_free) begin
        pend_valid <= 1'b0;
      end
      // Output register
      if (push_pend || (cmd.flush && pend_valid && out_free)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    // Capture the draw and start the scan
    if (accept && is_draw) begin
      key       <= item.char_code;
      issue_idx <= '0;
      col_base  <= $signed({{(COORD_W-POS_W){pen_col[POS_W-1]}}, pen_col});
      row_base  <= $signed({{(COORD_W-POS_W){pen_row[POS_W-1]}}, pen_row});
      row_start <= $signed({{(COORD_W-POS_W){pen_row[POS_W-1]}}, pen_row});
    end else if (cmd.scan && (issue_idx < SLOTS_N)) begin
      issue_idx <= issue_idx + (SLOT_W+1)'(1);
    end
    // Load the glyph on a hit
    if (cmd.scan && match) begin
      dots    <= rd_word[DOTS_W-1:0];
      step    <= '0;
      row_cnt <= '0;
    end else if (adv) begin
      dots <= dots >> 1;
      step <= step + STEP_W'(1);
      if (row_cnt == ROW_LAST) begin
        row_cnt  <= '0;
        row_base <= row_start;
        col_base <= col_base + s_ext;
      end else begin
        row_cnt  <= row_cnt + ROW_W'(1);
        row_base <= row_base + s_ext;
      end
    end
    if (adv && vis) begin
      pend_xf <= c_xf;
      pend_xl <= c_xl;
      pend_yf <= c_yf;
      pend_yl <= c_yl;
    end
    if (push_pend || (cmd.flush && pend_valid && out_free)) begin
      out_xf   <= pend_xf;
      out_xl   <= pend_xl;
      out_yf   <= pend_yf;
      out_yl   <= pend_yl;
      out_fill <= ink;
      out_last <= cmd.flush;
    end
  end

  assign result.valid      = out_valid;
  assign result.x_first    = out_xf;
  assign result.x_last     = out_xl;
  assign result.y_first    = out_yf;
  assign result.y_last     = out_yl;
  assign result.fill_value = out_fill;
  assign result.last       = out_last;

  assign sts.in_valid   = item.valid;
  assign sts.in_draw    = is_draw;
  assign sts.hit        = match;
  assign sts.scan_end   = rd_live && (rd_idx == SLOT_LAST) && !match;
  assign sts.emit_end   = adv && (step == STEP_LAST);
  assign sts.flush_done = !pend_valid || out_free;
  assign sts.pend_busy  = pend_valid;

  `SGB_ASSERT_NEXT(a_emit_holds, cmd.emit && vis && pend_valid && out_valid && !result.ready, $stable(step), "dot advanced over a full stage")
  `SGB_ASSERT_NOW(a_step_range, cmd.emit, step <= STEP_LAST, "dot step out of range")
  `SGB_ASSERT_NOW(a_hit_live, match, cmd.scan || rd_live, "hit without a scan read")

endmodule

// ----- rtl/scaled_glyph_blitter.sv -----
// Top level: character generator for a 3x5 bitmap font on a clipped panel
//
// Load items write one font slot and start items set pen, scale and ink. A
// draw item first scans the font memory one slot per cycle, lowest slot first,
// through its single registered read port, stopping at the first matching slot
// or after the last slot for an unknown code. The glyph's 15 dots are then
// stepped one per cycle while the result side does not stall, column by column,
// each visible dot giving one clipped square; a final flush state releases the
// last square, marked last. The pen column advances by four dot sizes per draw
// and saturates at 32767. Results wait in an output register, so the next item
// is accepted while the last square is still held.
module scaled_glyph_blitter (
  input  logic      clk,
  input  logic      rst,
  sgb_in_if.sink    item,
  sgb_out_if.source result
);
  import sgb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence control
  sgb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Storage and arithmetic
  sgb_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .item   (item),
    .result (result)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the 3x5 font glyph blitter: square-by-square prediction
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sgb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int REPORT_MAX = 10;
  localparam int RANDOM_PER_PHASE = 26;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [SLOTF_W-1:0] slot;
    logic [CODE_W-1:0]  char_code;
    logic [DOTS_W-1:0]  glyph_bits;
    logic [POS_W-1:0]   start_x;
    logic [POS_W-1:0]   start_y;
    logic [SCALE_W-1:0] scale;
    logic [PIX_W-1:0]   pixel_value;
  } glyph_item_t;

  typedef struct {
    logic [XO_W-1:0]  x_first;
    logic [XO_W-1:0]  x_last;
    logic [YO_W-1:0]  y_first;
    logic [YO_W-1:0]  y_last;
    logic [PIX_W-1:0] fill_value;
    logic             last;
  } square_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgb_in_if  in_ch ();
  sgb_out_if out_ch ();

  scaled_glyph_blitter uut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  always #1 clk = ~clk;

  glyph_item_t glyph_items[$];
  glyph_item_t in_flight;
  square_t     square_queue[$];
  int          send_idle_pct = 6;
  int          recv_idle_pct = 80;
  int          mismatches = 0;
  int          cycles = 0;

  // Shadow of the font table and drawing state
  logic [CODE_W-1:0] font_code [GLYPH_SLOTS];
  logic [DOTS_W-1:0] font_dots [GLYPH_SLOTS];
  bit                font_live [GLYPH_SLOTS];
  int                pen_x = 0;
  int                pen_y = 0;
  int                dot_size = 1;
  logic [PIX_W-1:0]  ink = '0;

  // Clip one axis of a dot square; return 0 when it lies wholly off the panel
  function automatic bit clip_span(input int lo, input int span, input int limit,
                                   output int first, output int final_i);
    int hi;
    hi = lo + span - 1;
    first = 0;
    final_i = 0;
    if (hi < 0 || lo >= limit) return 1'b0;
    first = (lo < 0) ? 0 : lo;
    final_i = (hi >= limit) ? limit - 1 : hi;
    return 1'b1;
  endfunction

  // Update the shadow state and queue the squares that one beat produces
  task automatic render_item(input glyph_item_t it);
    int hit;
    int xf, xl, yf, yl;
    square_t sq;
    square_t batch[$];
    hit = -1;
    case (it.kind)
      KIND_LOAD: begin
        font_code[it.slot] = it.char_code;
        font_dots[it.slot] = it.glyph_bits;
        font_live[it.slot] = 1'b1;
      end
      KIND_START: begin
        pen_x = int'($signed(it.start_x));
        pen_y = int'($signed(it.start_y));
        dot_size = (it.scale == 0) ? 1 : int'(it.scale);
        ink = it.pixel_value;
      end
      KIND_DRAW: begin
        for (int i = 0; i < GLYPH_SLOTS; i++) begin
          if (hit < 0 && font_live[i] && font_code[i] == it.char_code) hit = i;
        end
        if (hit >= 0) begin
          for (int c = 0; c < FONT_COLUMNS; c++) begin
            for (int r = 0; r < FONT_ROWS; r++) begin
              if (font_dots[hit][c*FONT_ROWS + r] &&
                  clip_span(pen_x + c*dot_size, dot_size, PANEL_WIDTH, xf, xl) &&
                  clip_span(pen_y + r*dot_size, dot_size, PANEL_HEIGHT, yf, yl)) begin
                sq.x_first = xf[XO_W-1:0];
                sq.x_last = xl[XO_W-1:0];
                sq.y_first = yf[YO_W-1:0];
                sq.y_last = yl[YO_W-1:0];
                sq.fill_value = ink;
                sq.last = 1'b0;
                batch.push_back(sq);
              end
            end
          end
          if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
          foreach (batch[k]) square_queue.push_back(batch[k]);
        end
        // Advance the pen even for unknown characters; saturate at the limit
        pen_x = pen_x + (FONT_COLUMNS + 1) * dot_size;
        if (pen_x > PEN_MAX) pen_x = PEN_MAX;
      end
      default: ;
    endcase
  endtask

  // Build items; unused fields carry random noise
  function automatic glyph_item_t noise_item();
    glyph_item_t it;
    it.kind = KIND_UNUSED;
    it.slot = SLOTF_W'($urandom);
    it.char_code = CODE_W'($urandom);
    it.glyph_bits = DOTS_W'($urandom);
    it.start_x = POS_W'($urandom);
    it.start_y = POS_W'($urandom);
    it.scale = SCALE_W'($urandom);
    it.pixel_value = PIX_W'($urandom);
    return it;
  endfunction

  function automatic glyph_item_t load_item(input int slot, input int code, input int dots);
    glyph_item_t it;
    it = noise_item();
    it.kind = KIND_LOAD;
    it.slot = SLOTF_W'(slot);
    it.char_code = CODE_W'(code);
    it.glyph_bits = DOTS_W'(dots);
    return it;
  endfunction

  function automatic glyph_item_t start_item(input int x, input int y, input int scale,
                                             input int pix);
    glyph_item_t it;
    it = noise_item();
    it.kind = KIND_START;
    it.start_x = POS_W'(x);
    it.start_y = POS_W'(y);
    it.scale = SCALE_W'(scale);
    it.pixel_value = PIX_W'(pix);
    return it;
  endfunction

  function automatic glyph_item_t draw_item(input int code);
    glyph_item_t it;
    it = noise_item();
    it.kind = KIND_DRAW;
    it.char_code = CODE_W'(code);
    return it;
  endfunction

  // Queue random items: mostly draws from a loaded alphabet, mixed with loads, starts, noise and other codes
  task automatic queue_random(input int count);
    int made;
    int r;
    made = 0;
    while (made < count) begin
      r = int'($urandom_range(99));
      if (r < 10) begin
        glyph_items.push_back(load_item(int'($urandom_range(GLYPH_SLOTS-1)),
          ($urandom_range(99) < 70) ? 8'h30 + $urandom_range(15) : $urandom_range(255),
          ($urandom_range(9) == 0) ? 15'h7FFF : $urandom_range(32767)));
        made++;
      end else if (r < 25) begin
        glyph_items.push_back(start_item(
          ($urandom_range(99) < 80) ? int'($urandom_range(170)) - 30 :
                                      int'($urandom_range(65535)),
          ($urandom_range(99) < 80) ? int'($urandom_range(100)) - 30 :
                                      int'($urandom_range(65535)),
          ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(15),
          $urandom_range(255)));
        made++;
      end else if (r < 30) begin
        glyph_items.push_back(noise_item());
      end else if (r < 35) begin
        glyph_items.push_back(draw_item(int'($urandom_range(255))));
        made++;
      end else begin
        glyph_items.push_back(draw_item(8'h30 + int'($urandom_range(15))));
        made++;
      end
    end
  endtask

  // Hold until every queued beat has been taken
  task automatic wait_sent();
    while (glyph_items.size() != 0 || in_ch.valid) @(negedge clk);
  endtask

  // Driver: predict on each accepted beat, then present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) render_item(in_flight);
      if (!in_ch.valid || in_ch.ready) begin
        if (glyph_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = glyph_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= in_flight.kind;
          in_ch.slot <= in_flight.slot;
          in_ch.char_code <= in_flight.char_code;
          in_ch.glyph_bits <= in_flight.glyph_bits;
          in_ch.start_x <= in_flight.start_x;
          in_ch.start_y <= in_flight.start_y;
          in_ch.scale <= in_flight.scale;
          in_ch.pixel_value <= in_flight.pixel_value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: compare each result beat with the oldest expected square
  always @(posedge clk) begin
    square_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (square_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected square: x %0d..%0d y %0d..%0d fill %0d last %0d",
                   out_ch.x_first, out_ch.x_last, out_ch.y_first, out_ch.y_last,
                   out_ch.fill_value, out_ch.last);
      end else begin
        want = square_queue.pop_front();
        if (out_ch.x_first !== want.x_first || out_ch.x_last !== want.x_last ||
            out_ch.y_first !== want.y_first || out_ch.y_last !== want.y_last ||
            out_ch.fill_value !== want.fill_value || out_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("square mismatch: exp x %0d..%0d y %0d..%0d fill %0d last %0d, %s",
                     want.x_first, want.x_last, want.y_first, want.y_last,
                     want.fill_value, want.last,
                     $sformatf("got x %0d..%0d y %0d..%0d fill %0d last %0d",
                               out_ch.x_first, out_ch.x_last, out_ch.y_first,
                               out_ch.y_last, out_ch.fill_value, out_ch.last));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("scaled_glyph_blitter test failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.slot = '0;
    in_ch.char_code = '0;
    in_ch.glyph_bits = '0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.scale = '0;
    in_ch.pixel_value = '0;
    out_ch.ready = 1'b0;
    foreach (font_live[i]) begin
      font_live[i] = 1'b0;
      font_code[i] = '0;
      font_dots[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unknown draw before any load, ignored kind, duplicate codes
    glyph_items.push_back(draw_item(8'h41));
    glyph_items.push_back(noise_item());
    glyph_items.push_back(load_item(0, 8'h41, 15'h7FFF));
    glyph_items.push_back(load_item(5, 8'h41, 15'h5555));
    glyph_items.push_back(load_item(63, 8'hFF, 15'h2AAA));
    glyph_items.push_back(load_item(1, 8'h00, 15'h0000));
    // Draw before start uses the reset pen, size and ink
    glyph_items.push_back(draw_item(8'h41));
    glyph_items.push_back(start_item(0, 0, 0, 8'hFF));
    glyph_items.push_back(draw_item(8'hFF));
    glyph_items.push_back(draw_item(8'h00));
    // Pen at the far corners: everything hidden, then saturation of the column
    glyph_items.push_back(start_item(-32768, -32768, 15, 8'h00));
    glyph_items.push_back(draw_item(8'h41));
    glyph_items.push_back(start_item(32767, 32767, 15, 8'hAA));
    glyph_items.push_back(draw_item(8'h41));
    glyph_items.push_back(draw_item(8'h41));
    // Partial clipping on each panel edge
    glyph_items.push_back(start_item(122, 58, 4, 8'h55));
    glyph_items.push_back(draw_item(8'h41));
    glyph_items.push_back(start_item(-5, -7, 3, 8'h0F));
    glyph_items.push_back(draw_item(8'hFF));
    glyph_items.push_back(draw_item(8'h7E));
    glyph_items.push_back(load_item(0, 8'h42, 15'h7FFF));
    glyph_items.push_back(draw_item(8'h41));
    glyph_items.push_back(start_item(0, 59, 15, 8'h80));
    glyph_items.push_back(draw_item(8'h42));

    // Load the alphabet that random draws mostly pick from
    for (int k = 0; k < 16; k++)
      glyph_items.push_back(load_item(int'($urandom_range(GLYPH_SLOTS-1)), 8'h30 + k,
                                      int'($urandom_range(32767))));
    queue_random(RANDOM_PER_PHASE);
    wait_sent();

    // Swap idle rates, then run without idling
    send_idle_pct = 80;
    recv_idle_pct = 6;
    queue_random(RANDOM_PER_PHASE);
    wait_sent();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    wait_sent();

    // Drain, then watch for stray results
    while (square_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && square_queue.size() == 0) begin
      $display("scaled_glyph_blitter test passed");
    end else begin
      $display("scaled_glyph_blitter test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sgb_pkg.sv
rtl/sgb_if.sv
rtl/sgb_ctrl.sv
rtl/sgb_datapath.sv
rtl/scaled_glyph_blitter.sv
test/testbench.sv
